// ----- hw/rtl/aocl_pkg.sv -----
// Package for the A* open/closed list block: defaults, operation and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package aocl_pkg;

    localparam int OPEN_DEPTH_DEF   = 256;
    localparam int CLOSED_DEPTH_DEF = 1024;
    localparam int COORD_BITS_DEF   = 16;
    localparam int COST_BITS_DEF    = 32;
    localparam int TAG_BITS_DEF     = 16;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [2:0] ST_INSERTED    = 3'd0;
    localparam logic [2:0] ST_REPLACED    = 3'd1;
    localparam logic [2:0] ST_DUP_DROP    = 3'd2;
    localparam logic [2:0] ST_CLOSED_DROP = 3'd3;
    localparam logic [2:0] ST_OPEN_FULL   = 3'd4;
    localparam logic [2:0] ST_POPPED      = 3'd5;
    localparam logic [2:0] ST_EMPTY       = 3'd6;
    localparam logic [2:0] ST_CLEARED     = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CSCAN,
        S_OSCAN,
        S_SHUP,
        S_SHDN,
        S_FINISH
    } aocl_state_t;

    typedef struct packed {
        logic       load_item;
        logic       o_re;
        logic       o_we;
        logic       o_wsel_item;
        logic       c_re;
        logic       c_we;
        logic       got_load;
        logic       clr;
        logic       open_inc;
        logic       open_dec;
        logic       closed_inc;
        logic       out_load;
        logic       ovf;
        logic [2:0] code;
    } aocl_cmd_t;

    typedef struct packed {
        logic c_match;
        logic o_cell_eq;
        logic o_cost_gt;
        logic open_empty;
        logic open_full;
        logic closed_full;
        logic out_busy;
    } aocl_stat_t;

endpackage

// ----- hw/rtl/aocl_if.sv -----
// Valid/ready channel interfaces for the A* open/closed list block.
// Depends on nothing; widths come from parameters.
interface aocl_in_if #(
    parameter int COORD_BITS = 16,
    parameter int COST_BITS  = 32,
    parameter int TAG_BITS   = 16
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   kind;
    logic signed [COORD_BITS-1:0] cell_x;
    logic signed [COORD_BITS-1:0] cell_y;
    logic signed [COORD_BITS-1:0] cell_z;
    logic [COST_BITS-1:0]         cost;
    logic [TAG_BITS-1:0]          node_tag;

    modport source (output valid, kind, cell_x, cell_y, cell_z, cost, node_tag, input ready);
    modport sink (input valid, kind, cell_x, cell_y, cell_z, cost, node_tag, output ready);
endinterface

interface aocl_out_if #(
    parameter int COORD_BITS = 16,
    parameter int COST_BITS  = 32,
    parameter int TAG_BITS   = 16,
    parameter int COUNT_BITS = 9
);
    logic                         valid;
    logic                         ready;
    logic [2:0]                   status;
    logic                         closed_overflow;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic [COST_BITS-1:0]         out_cost;
    logic [TAG_BITS-1:0]          out_tag;
    logic [COUNT_BITS-1:0]        open_count;

    modport source (output valid, status, closed_overflow, out_x, out_y, out_z, out_cost,
                    out_tag, open_count, input ready);
    modport sink (input valid, status, closed_overflow, out_x, out_y, out_z, out_cost,
                  out_tag, open_count, output ready);
endinterface

// ----- hw/rtl/astar_open_closed_list.sv -----
// A* open/closed list. A clear or empty pop goes straight to the result; a pop reads each
// open entry, keeps the first and moves the rest down; an insert scans the closed list and
// then the open list, then moves later entries up, one per cycle through the single ports.
// One transaction is worked at a time; the result register lets the next transaction in.
// Reset (rst_n, asynchronous, active low) empties both lists at once; no clearing pass.
// Depends on aocl_pkg, aocl_if, aocl_dp and aocl_ctrl.
module astar_open_closed_list #(
    parameter int OPEN_DEPTH   = aocl_pkg::OPEN_DEPTH_DEF,
    parameter int CLOSED_DEPTH = aocl_pkg::CLOSED_DEPTH_DEF,
    parameter int COORD_BITS   = aocl_pkg::COORD_BITS_DEF,
    parameter int COST_BITS    = aocl_pkg::COST_BITS_DEF,
    parameter int TAG_BITS     = aocl_pkg::TAG_BITS_DEF
) (
    input logic     clk,
    input logic     rst_n,
    aocl_in_if.sink  req,
    aocl_out_if.source rsp
);
    localparam int OAW = $clog2(OPEN_DEPTH);
    localparam int CAW = $clog2(CLOSED_DEPTH);
    localparam int OCW = $clog2(OPEN_DEPTH + 1);
    localparam int CCW = $clog2(CLOSED_DEPTH + 1);

    // Command and status between the sequencer and the datapath.
    aocl_pkg::aocl_cmd_t  cmd;
    aocl_pkg::aocl_stat_t stat;
    logic [OAW-1:0]       o_raddr;
    logic [OAW-1:0]       o_waddr;
    logic [CAW-1:0]       c_raddr;
    logic [OCW-1:0]       open_used;
    logic [CCW-1:0]       closed_used;

    // For an insert the controller walks the closed list, then the open list (finding the
    // insert point and any entry for the same cell), then shifts open entries one per cycle.
    aocl_ctrl #(
        .OPEN_DEPTH   (OPEN_DEPTH),
        .CLOSED_DEPTH (CLOSED_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_kind     (req.kind),
        .in_ready    (req.ready),
        .stat        (stat),
        .open_used   (open_used),
        .closed_used (closed_used),
        .cmd         (cmd),
        .o_raddr     (o_raddr),
        .o_waddr     (o_waddr),
        .c_raddr     (c_raddr)
    );

    // The datapath holds both list memories, the fill counts and the result register.
    aocl_dp #(
        .OPEN_DEPTH   (OPEN_DEPTH),
        .CLOSED_DEPTH (CLOSED_DEPTH),
        .COORD_BITS   (COORD_BITS),
        .COST_BITS    (COST_BITS),
        .TAG_BITS     (TAG_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cell_x          (req.cell_x),
        .cell_y          (req.cell_y),
        .cell_z          (req.cell_z),
        .cost            (req.cost),
        .node_tag        (req.node_tag),
        .cmd             (cmd),
        .o_raddr         (o_raddr),
        .o_waddr         (o_waddr),
        .c_raddr         (c_raddr),
        .stat            (stat),
        .open_used       (open_used),
        .closed_used     (closed_used),
        .out_ready       (rsp.ready),
        .out_valid       (rsp.valid),
        .status          (rsp.status),
        .closed_overflow (rsp.closed_overflow),
        .out_x           (rsp.out_x),
        .out_y           (rsp.out_y),
        .out_z           (rsp.out_z),
        .out_cost        (rsp.out_cost),
        .out_tag         (rsp.out_tag),
        .open_count      (rsp.open_count)
    );

endmodule

// ----- hw/rtl/aocl_dp.sv -----
// Datapath of the A* open/closed list: list memories, counters, comparators, output register.
// Depends on aocl_pkg.
module aocl_dp #(
    parameter int OPEN_DEPTH   = aocl_pkg::OPEN_DEPTH_DEF,
    parameter int CLOSED_DEPTH = aocl_pkg::CLOSED_DEPTH_DEF,
    parameter int COORD_BITS   = aocl_pkg::COORD_BITS_DEF,
    parameter int COST_BITS    = aocl_pkg::COST_BITS_DEF,
    parameter int TAG_BITS     = aocl_pkg::TAG_BITS_DEF,
    localparam int OAW = $clog2(OPEN_DEPTH),
    localparam int CAW = $clog2(CLOSED_DEPTH),
    localparam int OCW = $clog2(OPEN_DEPTH + 1),
    localparam int CCW = $clog2(CLOSED_DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic signed [COORD_BITS-1:0] cell_x,
    input  logic signed [COORD_BITS-1:0] cell_y,
    input  logic signed [COORD_BITS-1:0] cell_z,
    input  logic [COST_BITS-1:0]         cost,
    input  logic [TAG_BITS-1:0]          node_tag,
    input  aocl_pkg::aocl_cmd_t          cmd,
    input  logic [OAW-1:0]               o_raddr,
    input  logic [OAW-1:0]               o_waddr,
    input  logic [CAW-1:0]               c_raddr,
    output aocl_pkg::aocl_stat_t         stat,
    output logic [OCW-1:0]               open_used,
    output logic [CCW-1:0]               closed_used,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [2:0]                   status,
    output logic                         closed_overflow,
    output logic signed [COORD_BITS-1:0] out_x,
    output logic signed [COORD_BITS-1:0] out_y,
    output logic signed [COORD_BITS-1:0] out_z,
    output logic [COST_BITS-1:0]         out_cost,
    output logic [TAG_BITS-1:0]          out_tag,
    output logic [OCW-1:0]               open_count
);
    localparam int OW = 3 * COORD_BITS + COST_BITS + TAG_BITS;
    localparam int CW = 3 * COORD_BITS + COST_BITS;

    logic [OW-1:0] open_mem [OPEN_DEPTH];
    logic [CW-1:0] closed_mem [CLOSED_DEPTH];

    logic [OW-1:0]  item_reg;
    logic [OW-1:0]  got_reg;
    logic [OW-1:0]  o_rd_reg;
    logic [CW-1:0]  c_rd_reg;
    logic [OW-1:0]  o_wdata;
    logic [OCW-1:0] open_used_reg;
    logic [CCW-1:0] closed_used_reg;
    logic           out_valid_reg;

    logic [2:0]            status_reg;
    logic                  ovf_reg;
    logic [OW-1:0]         res_reg;
    logic [OCW-1:0]        count_reg;

    logic [3*COORD_BITS-1:0] item_cell;
    logic [COST_BITS-1:0]    item_cost;

    assign item_cell = item_reg[OW-1 -: 3*COORD_BITS];
    assign item_cost = item_reg[TAG_BITS +: COST_BITS];

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= {cell_x, cell_y, cell_z, cost, node_tag};
        end
        if (cmd.got_load)
        begin
            got_reg <= o_rd_reg;
        end
    end

    assign o_wdata = cmd.o_wsel_item ? item_reg : o_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.o_we)
        begin
            open_mem[o_waddr] <= o_wdata;
        end
        if (cmd.o_re)
        begin
            o_rd_reg <= open_mem[o_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.c_we)
        begin
            closed_mem[closed_used_reg[CAW-1:0]] <= got_reg[OW-1 -: CW];
        end
        if (cmd.c_re)
        begin
            c_rd_reg <= closed_mem[c_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_used_reg   <= '0;
            closed_used_reg <= '0;
        end
        else if (cmd.clr)
        begin
            open_used_reg   <= '0;
            closed_used_reg <= '0;
        end
        else
        begin
            if (cmd.open_inc)
            begin
                open_used_reg <= open_used_reg + 1'b1;
            end
            else if (cmd.open_dec)
            begin
                open_used_reg <= open_used_reg - 1'b1;
            end
            if (cmd.closed_inc)
            begin
                closed_used_reg <= closed_used_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        stat.c_match     = (c_rd_reg[CW-1 -: 3*COORD_BITS] == item_cell)
                           && (c_rd_reg[COST_BITS-1:0] <= item_cost);
        stat.o_cell_eq   = (o_rd_reg[OW-1 -: 3*COORD_BITS] == item_cell);
        stat.o_cost_gt   = (o_rd_reg[TAG_BITS +: COST_BITS] > item_cost);
        stat.open_empty  = (open_used_reg == '0);
        stat.open_full   = (open_used_reg == OCW'(OPEN_DEPTH));
        stat.closed_full = (closed_used_reg == CCW'(CLOSED_DEPTH));
        stat.out_busy    = out_valid_reg && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg <= cmd.code;
            ovf_reg    <= cmd.ovf;
            res_reg    <= (cmd.code == aocl_pkg::ST_POPPED) ? got_reg : '0;
            count_reg  <= open_used_reg;
        end
    end

    assign open_used       = open_used_reg;
    assign closed_used     = closed_used_reg;
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign closed_overflow = ovf_reg;
    assign out_x           = res_reg[OW-1 -: COORD_BITS];
    assign out_y           = res_reg[OW-COORD_BITS-1 -: COORD_BITS];
    assign out_z           = res_reg[OW-2*COORD_BITS-1 -: COORD_BITS];
    assign out_cost        = res_reg[TAG_BITS +: COST_BITS];
    assign out_tag         = res_reg[TAG_BITS-1:0];
    assign open_count      = count_reg;

endmodule

// ----- hw/rtl/aocl_ctrl.sv -----
// Controller of the A* open/closed list: sequences scans and shifts over the list memories.
// Depends on aocl_pkg.
module aocl_ctrl #(
    parameter int OPEN_DEPTH   = aocl_pkg::OPEN_DEPTH_DEF,
    parameter int CLOSED_DEPTH = aocl_pkg::CLOSED_DEPTH_DEF,
    localparam int OAW = $clog2(OPEN_DEPTH),
    localparam int CAW = $clog2(CLOSED_DEPTH),
    localparam int OCW = $clog2(OPEN_DEPTH + 1),
    localparam int CCW = $clog2(CLOSED_DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           in_kind,
    output logic                 in_ready,
    input  aocl_pkg::aocl_stat_t stat,
    input  logic [OCW-1:0]       open_used,
    input  logic [CCW-1:0]       closed_used,
    output aocl_pkg::aocl_cmd_t  cmd,
    output logic [OAW-1:0]       o_raddr,
    output logic [OAW-1:0]       o_waddr,
    output logic [CAW-1:0]       c_raddr
);
    aocl_pkg::aocl_state_t state_reg, state_next;
    logic [OCW-1:0] oidx_reg, oidx_next;
    logic [OCW-1:0] ochk_reg, ochk_next;
    logic [OCW-1:0] pos_reg, pos_next;
    logic [CCW-1:0] cidx_reg, cidx_next;
    logic           chk_v_reg, chk_v_next;
    logic           pos_f_reg, pos_f_next;
    logic           grow_reg, grow_next;
    logic           ovf_reg, ovf_next;
    logic [2:0]     code_reg, code_next;

    logic [OCW-1:0] ochk_inc;
    logic [OCW-1:0] ochk_dec;
    logic [OCW-1:0] oidx_dec;

    assign ochk_inc = ochk_reg + 1'b1;
    assign ochk_dec = ochk_reg - 1'b1;
    assign oidx_dec = oidx_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= aocl_pkg::S_IDLE;
            oidx_reg  <= '0;
            ochk_reg  <= '0;
            pos_reg   <= '0;
            cidx_reg  <= '0;
            chk_v_reg <= 1'b0;
            pos_f_reg <= 1'b0;
            grow_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
            code_reg  <= aocl_pkg::ST_INSERTED;
        end
        else
        begin
            state_reg <= state_next;
            oidx_reg  <= oidx_next;
            ochk_reg  <= ochk_next;
            pos_reg   <= pos_next;
            cidx_reg  <= cidx_next;
            chk_v_reg <= chk_v_next;
            pos_f_reg <= pos_f_next;
            grow_reg  <= grow_next;
            ovf_reg   <= ovf_next;
            code_reg  <= code_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        oidx_next  = oidx_reg;
        ochk_next  = ochk_reg;
        pos_next   = pos_reg;
        cidx_next  = cidx_reg;
        chk_v_next = chk_v_reg;
        pos_f_next = pos_f_reg;
        grow_next  = grow_reg;
        ovf_next   = ovf_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        cmd.ovf    = ovf_reg;
        o_raddr    = oidx_reg[OAW-1:0];
        o_waddr    = ochk_inc[OAW-1:0];
        c_raddr    = cidx_reg[CAW-1:0];
        in_ready   = 1'b0;

        unique case (state_reg)
            aocl_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    ovf_next      = 1'b0;
                    chk_v_next    = 1'b0;
                    unique case (in_kind)
                        aocl_pkg::KIND_INSERT:
                        begin
                            cidx_next  = '0;
                            state_next = aocl_pkg::S_CSCAN;
                        end
                        aocl_pkg::KIND_POP:
                        begin
                            if (stat.open_empty)
                            begin
                                code_next  = aocl_pkg::ST_EMPTY;
                                state_next = aocl_pkg::S_FINISH;
                            end
                            else
                            begin
                                oidx_next  = '0;
                                state_next = aocl_pkg::S_SHDN;
                            end
                        end
                        aocl_pkg::KIND_CLEAR:
                        begin
                            cmd.clr    = 1'b1;
                            code_next  = aocl_pkg::ST_CLEARED;
                            state_next = aocl_pkg::S_FINISH;
                        end
                        default:
                        begin
                            state_next = aocl_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            aocl_pkg::S_CSCAN:
            begin
                if (chk_v_reg && stat.c_match)
                begin
                    chk_v_next = 1'b0;
                    code_next  = aocl_pkg::ST_CLOSED_DROP;
                    state_next = aocl_pkg::S_FINISH;
                end
                else if (cidx_reg < closed_used)
                begin
                    cmd.c_re   = 1'b1;
                    cidx_next  = cidx_reg + 1'b1;
                    chk_v_next = 1'b1;
                end
                else
                begin
                    chk_v_next = 1'b0;
                    oidx_next  = '0;
                    pos_f_next = 1'b0;
                    state_next = aocl_pkg::S_OSCAN;
                end
            end

            aocl_pkg::S_OSCAN:
            begin
                if (chk_v_reg && stat.o_cell_eq)
                begin
                    chk_v_next = 1'b0;
                    if (stat.o_cost_gt)
                    begin
                        // The new entry goes ahead of the stale one; entries
                        // between the insert point and the stale slot move up.
                        pos_next   = pos_f_reg ? pos_reg : ochk_reg;
                        oidx_next  = ochk_reg;
                        grow_next  = 1'b0;
                        code_next  = aocl_pkg::ST_REPLACED;
                        state_next = aocl_pkg::S_SHUP;
                    end
                    else
                    begin
                        code_next  = aocl_pkg::ST_DUP_DROP;
                        state_next = aocl_pkg::S_FINISH;
                    end
                end
                else
                begin
                    if (chk_v_reg && stat.o_cost_gt && !pos_f_reg)
                    begin
                        pos_next   = ochk_reg;
                        pos_f_next = 1'b1;
                    end
                    if (oidx_reg < open_used)
                    begin
                        cmd.o_re   = 1'b1;
                        ochk_next  = oidx_reg;
                        oidx_next  = oidx_reg + 1'b1;
                        chk_v_next = 1'b1;
                    end
                    else
                    begin
                        chk_v_next = 1'b0;
                        if (stat.open_full)
                        begin
                            code_next  = aocl_pkg::ST_OPEN_FULL;
                            state_next = aocl_pkg::S_FINISH;
                        end
                        else
                        begin
                            if (pos_f_reg)
                            begin
                                pos_next = pos_reg;
                            end
                            else if (chk_v_reg && stat.o_cost_gt)
                            begin
                                pos_next = ochk_reg;
                            end
                            else
                            begin
                                pos_next = open_used;
                            end
                            oidx_next  = open_used;
                            grow_next  = 1'b1;
                            code_next  = aocl_pkg::ST_INSERTED;
                            state_next = aocl_pkg::S_SHUP;
                        end
                    end
                end
            end

            aocl_pkg::S_SHUP:
            begin
                if (chk_v_reg)
                begin
                    cmd.o_we = 1'b1;
                end
                if (oidx_reg > pos_reg)
                begin
                    cmd.o_re   = 1'b1;
                    o_raddr    = oidx_dec[OAW-1:0];
                    oidx_next  = oidx_dec;
                    ochk_next  = oidx_dec;
                    chk_v_next = 1'b1;
                end
                else if (chk_v_reg)
                begin
                    chk_v_next = 1'b0;
                end
                else
                begin
                    cmd.o_we        = 1'b1;
                    cmd.o_wsel_item = 1'b1;
                    o_waddr         = pos_reg[OAW-1:0];
                    cmd.open_inc    = grow_reg;
                    state_next      = aocl_pkg::S_FINISH;
                end
            end

            aocl_pkg::S_SHDN:
            begin
                o_waddr = ochk_dec[OAW-1:0];
                if (chk_v_reg)
                begin
                    if (ochk_reg == '0)
                    begin
                        cmd.got_load = 1'b1;
                    end
                    else
                    begin
                        cmd.o_we = 1'b1;
                    end
                end
                if (oidx_reg < open_used)
                begin
                    cmd.o_re   = 1'b1;
                    ochk_next  = oidx_reg;
                    oidx_next  = oidx_reg + 1'b1;
                    chk_v_next = 1'b1;
                end
                else if (chk_v_reg)
                begin
                    chk_v_next = 1'b0;
                end
                else
                begin
                    cmd.open_dec = 1'b1;
                    if (stat.closed_full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        cmd.c_we       = 1'b1;
                        cmd.closed_inc = 1'b1;
                    end
                    code_next  = aocl_pkg::ST_POPPED;
                    state_next = aocl_pkg::S_FINISH;
                end
            end

            aocl_pkg::S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = aocl_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = aocl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for astar_open_closed_list: a queue-fed driver, a predictor of
// the open and closed lists, and a monitor that checks every result transaction.
// Depends on aocl_pkg, aocl_if and the astar_open_closed_list RTL.
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [31:0] cost;
        logic [15:0] tag;
    } op_t;

    // One list entry, in the open or the closed list.
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [31:0] cost;
        logic [15:0] tag;
    } node_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        ovf;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [31:0] cost;
        logic [15:0] tag;
        logic [8:0]  count;
    } outcome_t;

    localparam int OPEN_MAX   = aocl_pkg::OPEN_DEPTH_DEF;
    localparam int CLOSED_MAX = aocl_pkg::CLOSED_DEPTH_DEF;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    logic clk;
    logic rst_n;

    aocl_in_if  req_if ();
    aocl_out_if rsp_if ();

    astar_open_closed_list dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Stimulus waiting for the driver, and results the predictor says are on their way.
    op_t      pending_ops[$];
    outcome_t expected_outcomes[$];

    // Predictor copy of the two lists.
    node_t open_list[$];
    node_t closed_list[$];

    int  idle_mode;       // 0: sender 18%, receiver 61%; 1: swapped; 2: no idling
    int  hold_at;         // result count at which the receiver holds off
    bit  hold_off;
    int  results_seen;
    int  errors;
    int  status_seen[8];
    int  overflow_seen;
    op_t cur_op;

    // Works out the result of one accepted transaction and updates the predicted lists.
    function automatic void predict_list_step(input op_t op);
        outcome_t r;
        node_t    n;
        int       i;
        int       pos;
        bit       done;
        r = '0;
        n = '{op.x, op.y, op.z, op.cost, op.tag};
        done = 0;
        if (op.kind == KIND_IGNORED)
            return;
        if (op.kind == aocl_pkg::KIND_INSERT)
        begin
            // The closed list is searched first; a cheaper or equal closed record wins.
            for (i = 0; i < closed_list.size() && !done; i++)
                if (closed_list[i].x == n.x && closed_list[i].y == n.y &&
                    closed_list[i].z == n.z && closed_list[i].cost <= n.cost)
                begin
                    r.status = aocl_pkg::ST_CLOSED_DROP;
                    done = 1;
                end
            for (i = 0; i < open_list.size() && !done; i++)
                if (open_list[i].x == n.x && open_list[i].y == n.y && open_list[i].z == n.z)
                begin
                    done = 1;
                    if (n.cost < open_list[i].cost)
                    begin
                        open_list.delete(i);
                        r.status = aocl_pkg::ST_REPLACED;
                    end
                    else
                        r.status = aocl_pkg::ST_DUP_DROP;
                end
            if (!done && open_list.size() >= OPEN_MAX)
            begin
                r.status = aocl_pkg::ST_OPEN_FULL;
                done = 1;
            end
            if (!done)
                r.status = aocl_pkg::ST_INSERTED;
            if (r.status == aocl_pkg::ST_INSERTED || r.status == aocl_pkg::ST_REPLACED)
            begin
                // Equal costs keep arrival order: the new entry goes behind them.
                pos = 0;
                while (pos < open_list.size() && open_list[pos].cost <= n.cost)
                    pos++;
                open_list.insert(pos, n);
            end
        end
        else if (op.kind == aocl_pkg::KIND_POP)
        begin
            if (open_list.size() == 0)
                r.status = aocl_pkg::ST_EMPTY;
            else
            begin
                n = open_list.pop_front();
                r.status = aocl_pkg::ST_POPPED;
                r.x = n.x;
                r.y = n.y;
                r.z = n.z;
                r.cost = n.cost;
                r.tag = n.tag;
                if (closed_list.size() < CLOSED_MAX)
                    closed_list.insert(closed_list.size(), n);
                else
                    r.ovf = 1'b1;
            end
        end
        else
        begin
            open_list.delete();
            closed_list.delete();
            r.status = aocl_pkg::ST_CLEARED;
        end
        r.count = 9'(open_list.size());
        expected_outcomes.insert(expected_outcomes.size(), r);
    endfunction

    function automatic bit roll_idle(input bit is_sender);
        int pct;
        if (idle_mode == 2)
            return 0;
        pct = ((idle_mode == 0) == is_sender) ? 18 : 61;
        return $urandom_range(99) < pct;
    endfunction

    // Driver: records the accepted transaction, then offers the next one or idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid    <= 1'b0;
            req_if.kind     <= aocl_pkg::KIND_INSERT;
            req_if.cell_x   <= '0;
            req_if.cell_y   <= '0;
            req_if.cell_z   <= '0;
            req_if.cost     <= '0;
            req_if.node_tag <= '0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
                predict_list_step(cur_op);
            if (!req_if.valid || req_if.ready)
            begin
                if (pending_ops.size() != 0 && !roll_idle(1))
                begin
                    cur_op = pending_ops.pop_front();
                    req_if.valid    <= 1'b1;
                    req_if.kind     <= cur_op.kind;
                    req_if.cell_x   <= cur_op.x;
                    req_if.cell_y   <= cur_op.y;
                    req_if.cell_z   <= cur_op.z;
                    req_if.cost     <= cur_op.cost;
                    req_if.node_tag <= cur_op.tag;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    function automatic void report(input string field, input logic [31:0] e,
                                   input logic [31:0] a);
        if (e !== a)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, e, a);
            errors++;
        end
    endfunction

    // Long receiver hold-off, counted here and started at result number hold_at.
    initial
    begin
        hold_off = 1'b0;
        wait (hold_at > 0 && results_seen >= hold_at);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    // Monitor: checks each result transaction against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t e;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                results_seen++;
                if (expected_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result, status %0d", $time, rsp_if.status);
                    errors++;
                end
                else
                begin
                    e = expected_outcomes.pop_front();
                    report("status", 32'(e.status), 32'(rsp_if.status));
                    report("closed_overflow", 32'(e.ovf), 32'(rsp_if.closed_overflow));
                    report("out_x", 32'(e.x), 32'(unsigned'(rsp_if.out_x)));
                    report("out_y", 32'(e.y), 32'(unsigned'(rsp_if.out_y)));
                    report("out_z", 32'(e.z), 32'(unsigned'(rsp_if.out_z)));
                    report("out_cost", e.cost, rsp_if.out_cost);
                    report("out_tag", 32'(e.tag), 32'(rsp_if.out_tag));
                    report("open_count", 32'(e.count), 32'(rsp_if.open_count));
                    status_seen[rsp_if.status]++;
                    if (rsp_if.closed_overflow)
                        overflow_seen++;
                end
            end
            if (hold_off)
                rsp_if.ready <= 1'b0;
            else
                rsp_if.ready <= !roll_idle(0);
        end
    end

    function automatic op_t make_op(input logic [1:0] kind, input logic [15:0] x,
                                    input logic [15:0] y, input logic [15:0] z,
                                    input logic [31:0] cost, input logic [15:0] tag);
        make_op = '{kind, x, y, z, cost, tag};
    endfunction

    function automatic void push(input logic [1:0] kind, input logic [15:0] x,
                                 input logic [15:0] y, input logic [15:0] z,
                                 input logic [31:0] cost, input logic [15:0] tag);
        pending_ops.insert(pending_ops.size(), make_op(kind, x, y, z, cost, tag));
    endfunction

    // Random transaction: mostly a small grid of cells so that duplicates, replacements
    // and closed-list hits are common, sometimes full-range fields.
    function automatic op_t random_op();
        op_t o;
        int  r;
        bit  wide;
        r = $urandom_range(99);
        wide = ($urandom_range(4) == 0);
        o.kind = (r < 55) ? aocl_pkg::KIND_INSERT : (r < 92) ? aocl_pkg::KIND_POP :
                 (r < 97) ? aocl_pkg::KIND_CLEAR : KIND_IGNORED;
        o.x = wide ? 16'($urandom) : 16'($urandom_range(3));
        o.y = wide ? 16'($urandom) : 16'($urandom_range(3));
        o.z = wide ? 16'($urandom) : 16'($urandom_range(3));
        o.cost = $urandom_range(1) ? 32'($urandom_range(20)) : 32'($urandom);
        o.tag = 16'($urandom);
        return o;
    endfunction

    // Lets the sender run dry and waits until every predicted result has arrived.
    task automatic drain();
        while (pending_ops.size() != 0 || req_if.valid || expected_outcomes.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_burst(input int n);
        int  cnt;
        op_t o;
        cnt = 0;
        while (cnt < n)
        begin
            o = random_op();
            pending_ops.insert(pending_ops.size(), o);
            if (o.kind != KIND_IGNORED)
                cnt++;
        end
    endtask

    initial
    begin
        int i;
        idle_mode = 0;
        hold_at = -1;
        results_seen = 0;
        errors = 0;
        overflow_seen = 0;
        for (i = 0; i < 8; i++)
            status_seen[i] = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: empty pop, field extremes, duplicates, replacement of the only
        // entry, ties, closed-list hits at higher and equal cost, ignored kind.
        push(aocl_pkg::KIND_POP, '0, '0, '0, '0, '0);
        push(aocl_pkg::KIND_INSERT, 16'h8000, 16'h7fff, 16'hffff, 32'hffffffff, 16'hffff);
        push(aocl_pkg::KIND_INSERT, 16'h8000, 16'h7fff, 16'hffff, 32'hffffffff, 16'h0001);
        push(aocl_pkg::KIND_INSERT, 16'h8000, 16'h7fff, 16'hffff, 32'h00000000, 16'h0000);
        push(aocl_pkg::KIND_INSERT, 16'h7fff, 16'h8000, 16'h0000, 32'h00010000, 16'h1234);
        push(aocl_pkg::KIND_INSERT, 16'h0000, 16'h0000, 16'h0000, 32'h00010000, 16'haaaa);
        push(aocl_pkg::KIND_INSERT, 16'h0001, 16'h0000, 16'h0000, 32'h00010000, 16'h5555);
        push(KIND_IGNORED, 16'h0002, 16'h0002, 16'h0002, 32'h5, 16'h7);
        push(aocl_pkg::KIND_POP, '0, '0, '0, '0, '0);
        push(aocl_pkg::KIND_INSERT, 16'h8000, 16'h7fff, 16'hffff, 32'h00000001, 16'h00ff);
        push(aocl_pkg::KIND_INSERT, 16'h8000, 16'h7fff, 16'hffff, 32'h00000000, 16'h00fe);
        push(aocl_pkg::KIND_POP, '0, '0, '0, '0, '0);
        push(aocl_pkg::KIND_POP, '0, '0, '0, '0, '0);
        push(aocl_pkg::KIND_POP, '0, '0, '0, '0, '0);
        push(aocl_pkg::KIND_POP, '0, '0, '0, '0, '0);
        push(aocl_pkg::KIND_INSERT, 16'h7fff, 16'h8000, 16'h0000, 32'h00008000, 16'hbeef);
        push(aocl_pkg::KIND_POP, '0, '0, '0, '0, '0);
        push(aocl_pkg::KIND_CLEAR, '0, '0, '0, '0, '0);
        push(aocl_pkg::KIND_INSERT, 16'h0000, 16'h0000, 16'h0000, 32'h00000000, 16'h0000);
        push(aocl_pkg::KIND_POP, '0, '0, '0, '0, '0);
        push(aocl_pkg::KIND_CLEAR, '0, '0, '0, '0, '0);
        drain();

        // Fill phase: the open list is filled, so the full and replacement-while-full
        // cases are reached, then partly popped into the closed list and cleared.
        for (i = 0; i < OPEN_MAX; i++)
            push(aocl_pkg::KIND_INSERT, 16'(i), 16'(-i), 16'd0, 32'(i), 16'($urandom));
        push(aocl_pkg::KIND_INSERT, 16'h7000, 16'h7000, 16'h7000, 32'd3, 16'h0c0c);
        push(aocl_pkg::KIND_INSERT, 16'(OPEN_MAX - 1), 16'(-(OPEN_MAX - 1)), 16'd0,
             32'd100, 16'h0d0d);
        for (i = 0; i < 20; i++)
            push(aocl_pkg::KIND_POP, '0, '0, '0, '0, '0);
        push(aocl_pkg::KIND_CLEAR, '0, '0, '0, '0, '0);
        push(aocl_pkg::KIND_INSERT, 16'h4000, 16'h4000, 16'h4000, 32'd9, 16'h0e0e);
        push(aocl_pkg::KIND_INSERT, 16'h4001, 16'h4000, 16'h4000, 32'd8, 16'h0f0f);
        push(aocl_pkg::KIND_POP, '0, '0, '0, '0, '0);
        push(aocl_pkg::KIND_POP, '0, '0, '0, '0, '0);
        push(aocl_pkg::KIND_CLEAR, '0, '0, '0, '0, '0);
        drain();

        // Random part, first with the roles of the idling swapped, then with no idling.
        // Early in the second half the receiver holds off long enough to back up the block.
        idle_mode = 1;
        random_burst(78);
        drain();
        idle_mode = 2;
        hold_at = results_seen + 10;
        random_burst(78);
        drain();

        repeat (1400) @(posedge clk);
        $display("Checked %0d results: %0d inserted, %0d replaced, %0d popped, %0d empty pops,",
                 results_seen, status_seen[aocl_pkg::ST_INSERTED],
                 status_seen[aocl_pkg::ST_REPLACED], status_seen[aocl_pkg::ST_POPPED],
                 status_seen[aocl_pkg::ST_EMPTY]);
        $display("%0d open-full drops, %0d closed drops, %0d closed overflows, %0d clears.",
                 status_seen[aocl_pkg::ST_OPEN_FULL], status_seen[aocl_pkg::ST_CLOSED_DROP],
                 overflow_seen, status_seen[aocl_pkg::ST_CLEARED]);
        if (expected_outcomes.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_outcomes.size());
            errors++;
        end
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial
    begin
        #100_000_000;
        $display("Timeout with %0d results outstanding", expected_outcomes.size());
        $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/aocl_pkg.sv
hw/rtl/aocl_if.sv
hw/rtl/aocl_dp.sv
hw/rtl/aocl_ctrl.sv
hw/rtl/astar_open_closed_list.sv
test/tb.sv
